@@ rtl/laq_pkg.sv @@
// ----------------------------------------------------------------------------
// laq_pkg: shared types and constants for the look-at quaternion block
// Fixed-point format, field widths, branch codes and the front-to-back job.
// ----------------------------------------------------------------------------
package laq_pkg;

  // fraction bits of every input and output component (Q2.14)
  localparam int FRAC_BITS = 14;
  localparam int DW        = 16;  // component width
  localparam int NUM_W     = 32;  // signed numerator width
  localparam int ARG_W     = 32;  // unsigned root argument width
  localparam int ROOT_W    = ARG_W / 2;
  localparam int S_W       = ROOT_W + 1;

  // conversion branch: which component carries the root
  typedef enum logic [1:0] {
    BR_W,
    BR_X,
    BR_Y,
    BR_Z
  } br_t;

  // classified item: root argument plus the three numerators, in output
  // order with the diagonal component left out
  typedef struct packed {
    br_t                     br;
    logic [ARG_W-1:0]        arg;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
  } job_t;

endpackage

@@ rtl/laq_front.sv @@
// ----------------------------------------------------------------------------
// laq_front: input stage and classifier
// Builds the basis products, picks the conversion branch and forms the
// square-root argument and the three numerators.
// ----------------------------------------------------------------------------
module laq_front
  import laq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [DW-1:0] fx_i,
  input  logic signed [DW-1:0] fy_i,
  input  logic signed [DW-1:0] fz_i,
  output logic                 job_valid,
  input  logic                 job_ready,
  output job_t                 job_o
);

  localparam int EW = 36;
  localparam logic signed [EW-1:0] ONE_2F = EW'(1) << (2 * FRAC_BITS);

  logic                 s1_v_r;
  logic signed [DW-1:0] fx_r, fy_r, fz_r;
  logic signed [31:0]   pxy_r, pxx_r, pzz_r, pyz_r;
  logic                 s2_v_r;
  job_t                 job_r, job_nxt;
  logic                 en;

  logic signed [EW-1:0] rx, uy, gx, gy, gz, rz, ux, uz, tr, arg_s;
  logic signed [EW-1:0] n0, n1, n2;

  function automatic logic signed [EW-1:0] sx16(logic signed [DW-1:0] v);
    return EW'(v);
  endfunction

  function automatic logic signed [EW-1:0] sx32(logic signed [31:0] v);
    return EW'(v);
  endfunction

  // stage advances when its slot is free or being handed on
  assign en        = !s2_v_r || job_ready;
  assign in_ready  = en;
  assign job_valid = s2_v_r;
  assign job_o     = job_r;

  // basis terms at 2*FRAC_BITS fraction bits, branch pick
  always_comb begin
    rx = sx16(fz_r) <<< FRAC_BITS;
    rz = -(sx16(fx_r) <<< FRAC_BITS);
    gx = sx16(fx_r) <<< FRAC_BITS;
    gy = sx16(fy_r) <<< FRAC_BITS;
    gz = sx16(fz_r) <<< FRAC_BITS;
    ux = -sx32(pxy_r);
    uz = -sx32(pyz_r);
    uy = sx32(pxx_r) + sx32(pzz_r);
    tr = rx + uy + gz;
    if (tr > 0) begin
      job_nxt.br = BR_W;
      arg_s = tr + ONE_2F;
      n0 = gy - uz;
      n1 = rz - gx;
      n2 = ux;
    end else if (rx > uy && rx > gz) begin
      job_nxt.br = BR_X;
      arg_s = ONE_2F + rx - uy - gz;
      n0 = gy - uz;
      n1 = ux;
      n2 = rz + gx;
    end else if (uy > gz) begin
      job_nxt.br = BR_Y;
      arg_s = ONE_2F + uy - rx - gz;
      n0 = rz - gx;
      n1 = ux;
      n2 = uz + gy;
    end else begin
      job_nxt.br = BR_Z;
      arg_s = ONE_2F + gz - rx - uy;
      n0 = ux;
      n1 = rz + gx;
      n2 = uz + gy;
    end
    // negative argument clamps to zero
    job_nxt.arg  = arg_s[EW-1] ? '0 : arg_s[ARG_W-1:0];
    job_nxt.num0 = $signed(n0[NUM_W-1:0]);
    job_nxt.num1 = $signed(n1[NUM_W-1:0]);
    job_nxt.num2 = $signed(n2[NUM_W-1:0]);
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
    end
  end

  // payload: products, then classified job
  always_ff @(posedge clk) begin
    if (en) begin
      fx_r  <= fx_i;
      fy_r  <= fy_i;
      fz_r  <= fz_i;
      pxy_r <= fx_i * fy_i;
      pxx_r <= fx_i * fx_i;
      pzz_r <= fz_i * fz_i;
      pyz_r <= fy_i * fz_i;
      job_r <= job_nxt;
    end
  end

endmodule

@@ rtl/laq_fifo.sv @@
// ----------------------------------------------------------------------------
// laq_fifo: job queue between classifier and arithmetic back end
// Small register queue, full and empty from an entry count.
// ----------------------------------------------------------------------------
module laq_fifo
  import laq_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_data
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  job_t          mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic          push, pop;

  assign push_ready = (cnt_r != (AW+1)'(DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_data   = mem[rp_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      if (push && !pop) cnt_r <= cnt_r + 1'b1;
      else if (pop && !push) cnt_r <= cnt_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r] <= push_data;
  end

endmodule

@@ rtl/laq_back.sv @@
// ----------------------------------------------------------------------------
// laq_back: pipelined square root, three pipelined dividers, output register
// One root bit per stage, then one quotient bit per stage in every lane.
// ----------------------------------------------------------------------------
module laq_back
  import laq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              job_valid,
  output logic              job_ready,
  input  job_t              job_i,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [4*DW-1:0]   out_data
);

  localparam int QW = DW;  // quotient bits computed per lane

  typedef struct packed {
    br_t                     br;
    logic signed [NUM_W-1:0] num0;
    logic signed [NUM_W-1:0] num1;
    logic signed [NUM_W-1:0] num2;
    logic [ARG_W-1:0]        arg;
    logic [ROOT_W+3:0]       rem;
    logic [ROOT_W-1:0]       root;
  } sq_t;

  typedef struct packed {
    logic          neg;
    logic          ovf;
    logic [QW-1:0] lo;
    logic [S_W:0]  rem;
    logic [QW-1:0] q;
  } ln_t;

  typedef struct packed {
    br_t           br;
    logic [DW-1:0] diag;
    logic [S_W-1:0] s;
    ln_t [2:0]     ln;
  } dv_t;

  sq_t           sq_r [ROOT_W];
  logic [ROOT_W-1:0] sq_v_r;
  dv_t           dv_r [QW+1];
  logic [QW:0]   dv_v_r;
  logic          out_v_r;
  logic [4*DW-1:0] out_r, out_nxt;
  logic          en;
  sq_t           sq_in;
  dv_t           dv_in;
  logic signed [DW-1:0] c0, c1, c2;

  // one root bit: bring in two argument bits, try subtract
  function automatic sq_t sq_step(sq_t a);
    sq_t               b;
    logic [ROOT_W+3:0] r2;
    logic [ROOT_W+3:0] trial;
    b     = a;
    r2    = {a.rem[ROOT_W+1:0], a.arg[ARG_W-1 -: 2]};
    trial = {2'b00, a.root, 2'b01};
    b.arg = {a.arg[ARG_W-3:0], 2'b00};
    if (r2 >= trial) begin
      b.rem  = r2 - trial;
      b.root = {a.root[ROOT_W-2:0], 1'b1};
    end else begin
      b.rem  = r2;
      b.root = {a.root[ROOT_W-2:0], 1'b0};
    end
    return b;
  endfunction

  // lane setup: magnitude, sign, overflow when quotient needs > QW bits
  function automatic ln_t ln_init(logic signed [NUM_W-1:0] n, logic [S_W-1:0] s);
    ln_t              l;
    logic [NUM_W-1:0] mag;
    mag   = n[NUM_W-1] ? NUM_W'(-n) : NUM_W'(n);
    l.neg = n[NUM_W-1];
    l.ovf = ((S_W+1)'(mag[NUM_W-2:QW]) >= (S_W+1)'(s));
    l.rem = (S_W+1)'(mag[NUM_W-2:QW]);
    l.lo  = mag[QW-1:0];
    l.q   = '0;
    return l;
  endfunction

  // one quotient bit
  function automatic ln_t ln_step(ln_t a, logic [S_W-1:0] s);
    ln_t          b;
    logic [S_W:0] r2;
    b    = a;
    r2   = {a.rem[S_W-1:0], a.lo[QW-1]};
    b.lo = {a.lo[QW-2:0], 1'b0};
    if (r2 >= {1'b0, s}) begin
      b.rem = r2 - {1'b0, s};
      b.q   = {a.q[QW-2:0], 1'b1};
    end else begin
      b.rem = r2;
      b.q   = {a.q[QW-2:0], 1'b0};
    end
    return b;
  endfunction

  // one divider stage: every lane takes one quotient bit
  function automatic dv_t dv_step(dv_t a);
    dv_t b;
    b = a;
    for (int k = 0; k < 3; k++) b.ln[k] = ln_step(a.ln[k], a.s);
    return b;
  endfunction

  // signed, saturated quotient; zero divisor gives zero
  function automatic logic signed [DW-1:0] ln_out(ln_t l, logic szero);
    logic signed [DW-1:0] v;
    if (szero) begin
      v = '0;
    end else if (l.neg) begin
      if (l.ovf || l.q > QW'(32768)) v = 16'sh8000;
      else v = $signed(DW'(-l.q));
    end else begin
      if (l.ovf || l.q > QW'(32767)) v = 16'sh7fff;
      else v = $signed(l.q);
    end
    return v;
  endfunction

  // the whole pipe moves while the output slot frees up
  assign en        = !out_v_r || out_ready;
  assign job_ready = en;
  assign out_valid = out_v_r;
  assign out_data  = out_r;

  // pipe entry and root-to-divider handoff
  always_comb begin
    sq_in.br   = job_i.br;
    sq_in.num0 = job_i.num0;
    sq_in.num1 = job_i.num1;
    sq_in.num2 = job_i.num2;
    sq_in.arg  = job_i.arg;
    sq_in.rem  = '0;
    sq_in.root = '0;

    dv_in.br    = sq_r[ROOT_W-1].br;
    dv_in.diag  = DW'(sq_r[ROOT_W-1].root >> 1);
    dv_in.s     = {sq_r[ROOT_W-1].root, 1'b0};
    dv_in.ln[0] = ln_init(sq_r[ROOT_W-1].num0, {sq_r[ROOT_W-1].root, 1'b0});
    dv_in.ln[1] = ln_init(sq_r[ROOT_W-1].num1, {sq_r[ROOT_W-1].root, 1'b0});
    dv_in.ln[2] = ln_init(sq_r[ROOT_W-1].num2, {sq_r[ROOT_W-1].root, 1'b0});
  end

  // result assembly by branch
  always_comb begin
    c0 = ln_out(dv_r[QW].ln[0], dv_r[QW].s == '0);
    c1 = ln_out(dv_r[QW].ln[1], dv_r[QW].s == '0);
    c2 = ln_out(dv_r[QW].ln[2], dv_r[QW].s == '0);
    case (dv_r[QW].br)
      BR_W:    out_nxt = {c2, c1, c0, dv_r[QW].diag};
      BR_X:    out_nxt = {c2, c1, dv_r[QW].diag, c0};
      BR_Y:    out_nxt = {c2, dv_r[QW].diag, c1, c0};
      BR_Z:    out_nxt = {dv_r[QW].diag, c2, c1, c0};
      default: out_nxt = '0;
    endcase
  end

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_v_r  <= '0;
      dv_v_r  <= '0;
      out_v_r <= 1'b0;
    end else if (en) begin
      sq_v_r  <= {sq_v_r[ROOT_W-2:0], job_valid};
      dv_v_r  <= {dv_v_r[QW-1:0], sq_v_r[ROOT_W-1]};
      out_v_r <= dv_v_r[QW];
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= sq_step(sq_in);
      for (int i = 1; i < ROOT_W; i++) sq_r[i] <= sq_step(sq_r[i-1]);
      dv_r[0] <= dv_in;
      for (int i = 1; i <= QW; i++) dv_r[i] <= dv_step(dv_r[i-1]);
      out_r <= out_nxt;
    end
  end

endmodule

@@ rtl/look_at_quaternion.sv @@
// ----------------------------------------------------------------------------
// look_at_quaternion: forward vector to orientation quaternion
// Top level: classifier front end, job queue, root and divide back end.
// ----------------------------------------------------------------------------
// One forward vector in, one quaternion out, one transfer per clock
// sustained while the output is not stalled. Each result is registered
// through the 16-stage square root (one root bit per stage) and the
// 16-stage dividers (one quotient bit per stage) that follow it. A
// four-entry queue between classifier and back end lets each side stall
// on its own; the output register holds a result while the next input is
// still taken.
module look_at_quaternion
  import laq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // forward_x, forward_y, forward_z
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata   // quat_w, quat_x, quat_y, quat_z
);

  logic job_v_f, job_r_f, job_v_b, job_r_b;
  job_t job_f, job_b;

  laq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .fx_i      ($signed(in_tdata[15:0])),
    .fy_i      ($signed(in_tdata[31:16])),
    .fz_i      ($signed(in_tdata[47:32])),
    .job_valid (job_v_f),
    .job_ready (job_r_f),
    .job_o     (job_f)
  );

  laq_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (job_v_f),
    .push_ready (job_r_f),
    .push_data  (job_f),
    .pop_valid  (job_v_b),
    .pop_ready  (job_r_b),
    .pop_data   (job_b)
  );

  laq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_v_b),
    .job_ready (job_r_b),
    .job_i     (job_b),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

@@ rtl/laq_checker.sv @@
// ----------------------------------------------------------------------------
// laq_checker: port-level checks for look_at_quaternion
// Tracks items in flight and checks output behavior over time.
// ----------------------------------------------------------------------------
module laq_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  logic [6:0] inflight_r;
  logic       in_xfer, out_xfer;

  assign in_xfer  = in_tvalid && in_tready;
  assign out_xfer = out_tvalid && out_tready;

  // items accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else if (in_xfer && !out_xfer) begin
      inflight_r <= inflight_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      inflight_r <= inflight_r - 1'b1;
    end
  end

  // valid stays high until the result is taken
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result dropped while stalled");

  // reset empties the pipe
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result after reset");

  // no result without an earlier accepted item
  a_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> inflight_r != '0)
    else $error("result without input");

  // the root component is never negative, so not all four signs may be set
  a_diag: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[15] && out_tdata[31] && out_tdata[47] && out_tdata[63]))
    else $error("all components negative");

endmodule

bind look_at_quaternion laq_checker u_laq_checker (.*);
